### src/circular_array_deque_defines.svh
// Assertion macros used by the deque checker.
`ifndef CIRCULAR_ARRAY_DEQUE_DEFINES_SVH
`define CIRCULAR_ARRAY_DEQUE_DEFINES_SVH

// same-cycle implication
`define CAD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication
`define CAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

### src/cad_pkg.sv
// Types and constants for the circular array deque.
`default_nettype none
package cad_pkg;
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam cmd_t CMD_INS_FRONT = 3'd0;
    localparam cmd_t CMD_INS_REAR  = 3'd1;
    localparam cmd_t CMD_DEL_FRONT = 3'd2;
    localparam cmd_t CMD_DEL_REAR  = 3'd3;
    localparam cmd_t CMD_PEEK      = 3'd4;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_RESULT = 1'b1
    } fsm_t;

    // per-cell move controls
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load;
    } cad_cell_ctl_t;

    // shared controls from the sequencer
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load_rear;
    } cad_row_ctl_t;

    // result bookkeeping from the sequencer
    typedef struct packed {
        logic    load_result;
        status_t status;
        cnt_t    count;
    } cad_stat_t;
endpackage
`default_nettype wire

### src/cad_cell.sv
// One storage cell of the deque row.
`default_nettype none
module cad_cell
    import cad_pkg::*;
(
    input  wire logic          aclk,
    input  wire cad_cell_ctl_t ctl,
    input  wire data_t         left_data,
    input  wire data_t         right_data,
    input  wire data_t         load_data,
    output data_t              data
);
    data_t data_reg;
    data_t data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift_right) begin
            data_next = left_data;
        end else if (ctl.shift_left) begin
            data_next = right_data;
        end else if (ctl.load) begin
            data_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
endmodule
`default_nettype wire

### src/cad_ctrl.sv
// Sequencer: handshake, fill count, status and row controls.
`default_nettype none
module cad_ctrl
    import cad_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_tvalid,
    input  wire cmd_t   s_command,
    output logic        s_tready,
    input  wire logic   m_tready,
    output logic        m_tvalid,
    output cad_row_ctl_t row_ctl,
    output cad_stat_t   stat
);
    fsm_t    state_reg, state_next;
    cnt_t    count_reg, count_next;
    status_t status_reg, status_next;
    logic    m_tvalid_reg, m_tvalid_next;

    logic    accept;
    logic    full;
    logic    empty;
    logic    is_ins;
    logic    is_del;
    logic    load_result;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign is_ins = (s_command == CMD_INS_FRONT) || (s_command == CMD_INS_REAR);
    assign is_del = (s_command == CMD_DEL_FRONT) || (s_command == CMD_DEL_REAR);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:   if (accept) state_next = FSM_RESULT;
            FSM_RESULT: state_next = FSM_IDLE;
            default:    state_next = FSM_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready    = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            FSM_IDLE:   s_tready = !m_tvalid_reg || m_tready;
            FSM_RESULT: load_result = 1'b1;
            default: begin
                s_tready    = 1'b0;
                load_result = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        row_ctl.shift_right = accept && (s_command == CMD_INS_FRONT) && !full;
        row_ctl.load_rear   = accept && (s_command == CMD_INS_REAR) && !full;
        row_ctl.shift_left  = accept && (s_command == CMD_DEL_FRONT) && !empty;

        count_next  = count_reg;
        status_next = status_reg;
        if (accept) begin
            status_next = ST_DONE;
            if (is_ins) begin
                if (full) status_next = ST_OVERFLOW;
                else count_next = count_reg + CNT_W'(1);
            end else if (is_del) begin
                if (empty) status_next = ST_UNDERFLOW;
                else count_next = count_reg - CNT_W'(1);
            end
        end

        m_tvalid_next = m_tvalid_reg;
        if (load_result) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            status_reg   <= ST_DONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid         = m_tvalid_reg;
    assign stat.load_result = load_result;
    assign stat.status      = status_reg;
    assign stat.count       = count_reg;
endmodule
`default_nettype wire

### src/circular_array_deque.sv
// Double-ended queue of signed 32-bit words held in a row of shifting cells.
// Input channel s_: s_tuser carries the command (insert front, insert rear,
// delete front, delete rear, peek; codes 5 to 7 act as peek), s_tdata the
// value to insert. Result channel m_: one item per input item, carrying the
// status (done, overflow, underflow), the empty and full flags and the front
// and rear values after the step; both values read zero when empty.
// The row keeps the front element in cell 0; insert front shifts the row up,
// delete front shifts it down, insert rear writes the cell at the fill count,
// delete rear only lowers the count.
// The result item is presented once the sequencer has passed through its result
// state and the result registers have loaded.
// No new input item is taken until the result of the last one has been
// loaded into the result registers.
// Reset (aresetn low, synchronous) empties the deque and drops any pending
// result; cell contents are not cleared. While a result is pending and
// m_tready is low the result holds and no new input item is taken.
`default_nettype none
module circular_array_deque
    import cad_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [2:0]  s_tuser,   // [2:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] front_value, [63:32] rear_value
    output logic [3:0]       m_tuser    // [1:0] status, [2] is_empty, [3] is_full
);
    cad_row_ctl_t row_ctl;
    cad_stat_t    stat;
    data_t        cell_data [DEPTH];

    cad_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_command (s_tuser),
        .s_tready  (s_tready),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .row_ctl   (row_ctl),
        .stat      (stat)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cad_cell_ctl_t ctl;
        data_t         left_data;
        data_t         right_data;

        assign ctl.shift_right = row_ctl.shift_right;
        assign ctl.shift_left  = row_ctl.shift_left;
        assign ctl.load        = row_ctl.load_rear && (stat.count == CNT_W'(i));

        if (i == 0) begin : g_first
            assign left_data = s_tdata;
        end else begin : g_mid
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_inner
            assign right_data = cell_data[i+1];
        end

        cad_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .left_data  (left_data),
            .right_data (right_data),
            .load_data  (s_tdata),
            .data       (cell_data[i])
        );
    end

    cnt_t    rear_pos;
    idx_t    rear_idx;
    logic    empty;
    data_t   front_reg, front_next;
    data_t   rear_reg, rear_next;
    status_t status_reg, status_next;
    logic    empty_reg, empty_next;
    logic    full_reg, full_next;

    assign rear_pos = stat.count - CNT_W'(1);
    assign rear_idx = rear_pos[IDX_W-1:0];
    assign empty    = (stat.count == '0);

    always_comb begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        status_next = status_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;
        if (stat.load_result) begin
            front_next  = empty ? '0 : cell_data[0];
            rear_next   = empty ? '0 : cell_data[rear_idx];
            status_next = stat.status;
            empty_next  = empty;
            full_next   = (stat.count == CNT_W'(DEPTH));
        end
    end

    always_ff @(posedge aclk) begin
        front_reg  <= front_next;
        rear_reg   <= rear_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
    end

    assign m_tdata = {rear_reg, front_reg};
    assign m_tuser = {full_reg, empty_reg, status_reg};
endmodule
`default_nettype wire

### src/circular_array_deque_checker.sv
// Port-level checks for the deque, bound to the top level.
`default_nettype none
`include "circular_array_deque_defines.svh"
module circular_array_deque_checker
    import cad_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [3:0]  m_tuser
);
    `CAD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `CAD_ASSERT_NOW(a_flags, aclk, aresetn, m_tvalid, !(m_tuser[2] && m_tuser[3]))
    `CAD_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser[2], m_tdata == '0)
    `CAD_ASSERT_NOW(a_ovf_full, aclk, aresetn,
        m_tvalid && (m_tuser[1:0] == ST_OVERFLOW), m_tuser[3])
    `CAD_ASSERT_NOW(a_unf_empty, aclk, aresetn,
        m_tvalid && (m_tuser[1:0] == ST_UNDERFLOW), m_tuser[2])
endmodule

bind circular_array_deque circular_array_deque_checker u_checker (.*);
`default_nettype wire
